// ===== sv/biq_pkg.sv =====
`default_nettype none
package biq_pkg;

  localparam int unsigned MAX_STAGES_DEF = 6;
  localparam int unsigned COEF_WIDTH_DEF = 32;
  localparam int unsigned SAMPLE_W       = 24;
  localparam int unsigned VAL_W          = 32;
  localparam int unsigned VAL_FRAC       = 24;
  localparam int unsigned SAMPLE_SHIFT   = VAL_FRAC - (SAMPLE_W - 1);
  localparam int unsigned SLOTS          = 5;
  localparam int unsigned OP_W           = 2;
  localparam int unsigned IDX_W          = 5;
  localparam int unsigned STAGES_W       = 3;

  localparam logic [OP_W-1:0] OP_FILTER = 2'd0;
  localparam logic [OP_W-1:0] OP_COEF   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [2:0] TERM_B0 = 3'd0;
  localparam logic [2:0] TERM_B1 = 3'd1;
  localparam logic [2:0] TERM_B2 = 3'd2;
  localparam logic [2:0] TERM_A1 = 3'd3;
  localparam logic [2:0] TERM_A2 = 3'd4;

  typedef struct packed {
    logic start;
    logic clear;
    logic negate;
  } mac_ctrl_t;

endpackage
`default_nettype wire

// ===== sv/biq_mac.sv =====
`default_nettype none
module biq_mac #(
  parameter int unsigned CW = biq_pkg::COEF_WIDTH_DEF,
  parameter int unsigned AW = CW + biq_pkg::VAL_W + 3
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire  biq_pkg::mac_ctrl_t      ctrl_i,
  input  wire  [biq_pkg::VAL_W-1:0]     opnd_i,
  input  wire  [CW-1:0]                 coef_i,
  output logic                          busy_o,
  output logic [AW-1:0]                 acc_o
);

  localparam int unsigned CNT_W = $clog2(CW);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic             neg_q;
  logic [AW-1:0]    m_q;
  logic [CW-1:0]    c_q;
  logic [AW-1:0]    acc_q;
  logic             last;

  assign last   = (cnt_q == CNT_W'(CW - 1));
  assign busy_o = busy_q;
  assign acc_o  = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (ctrl_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (last) begin
        busy_q <= 1'b0;
      end
    end
  end

  // the top coefficient bit carries negative weight
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      m_q   <= AW'($signed(opnd_i));
      c_q   <= coef_i;
      neg_q <= ctrl_i.negate;
      if (ctrl_i.clear) begin
        acc_q <= '0;
      end
    end else if (busy_q) begin
      if (c_q[0]) begin
        if (neg_q ^ last) begin
          acc_q <= acc_q - m_q;
        end else begin
          acc_q <= acc_q + m_q;
        end
      end
      m_q <= {m_q[AW-2:0], 1'b0};
      c_q <= {1'b0, c_q[CW-1:1]};
    end
  end

endmodule
`default_nettype wire

// ===== sv/iq_biquad_cascade_lowpass.sv =====
// I/Q cascade of up to MAX_STAGES direct-form-I biquads. Each s_axis word carries an
// opcode: filter one I/Q pair (one m_axis word back), write one coefficient, or clear
// all history; opcode 3 is dropped. After a filter word is taken, ready stays low while
// both channels run through the applied stages, and the result appears on the master
// side in the same cycle that ready rises again. That time is set by the one bit-serial
// multiplier that works every product one coefficient bit per cycle. Coefficient and
// clear words leave ready high. One finished result may wait on the master side while
// the next word is taken; a second result holds until the first leaves. Write
// active_stages only while idle.
`default_nettype none
module iq_biquad_cascade_lowpass #(
  parameter int unsigned MAX_STAGES = biq_pkg::MAX_STAGES_DEF,
  parameter int unsigned COEF_WIDTH = biq_pkg::COEF_WIDTH_DEF
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire  [biq_pkg::STAGES_W-1:0]        cfg_wdata_i,
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  // opcode, sample_i, sample_q, coef_index, coef_value, zero fill
  input  wire  [((biq_pkg::OP_W + 2*biq_pkg::SAMPLE_W + biq_pkg::IDX_W + COEF_WIDTH
                  + 7) / 8) * 8 - 1:0]        s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  // filtered_i, filtered_q
  output logic [2*biq_pkg::SAMPLE_W-1:0]      m_axis_tdata,
  // clipped
  output logic                                m_axis_tuser
);

  localparam int unsigned SW    = biq_pkg::SAMPLE_W;
  localparam int unsigned VW    = biq_pkg::VAL_W;
  localparam int unsigned SH    = biq_pkg::SAMPLE_SHIFT;
  localparam int unsigned AW    = COEF_WIDTH + VW + 3;
  localparam int unsigned FRAC  = COEF_WIDTH - 4;
  localparam int unsigned NC    = MAX_STAGES * biq_pkg::SLOTS;
  localparam int unsigned NH    = MAX_STAGES * 2;
  localparam int unsigned CI_W  = $clog2(NC);
  localparam int unsigned HI_W  = (NH > 1) ? $clog2(NH) : 1;
  localparam int unsigned ST_W  = $clog2(MAX_STAGES + 1);
  localparam int unsigned P_S_I = biq_pkg::OP_W;
  localparam int unsigned P_S_Q = P_S_I + SW;
  localparam int unsigned P_IDX = P_S_Q + SW;
  localparam int unsigned P_CV  = P_IDX + biq_pkg::IDX_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHK   = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;
  localparam logic [2:0] S_CHEND = 3'd5;

  logic [2:0]                    state_q, state_d;
  logic [biq_pkg::STAGES_W-1:0]  active_q;
  logic [ST_W-1:0]               stage_q;
  logic [2:0]                    term_q;
  logic                          chan_q;
  logic                          clip_q;
  logic [VW-1:0]                 x_q;
  logic [SW-1:0]                 samp_q_q;
  logic [SW-1:0]                 res_i_q;
  logic                          out_valid_q;
  logic [2*SW-1:0]               out_data_q;
  logic                          out_clip_q;
  logic [COEF_WIDTH-1:0]         coef_q [NC];
  logic [VW-1:0]                 hx1_q [NH];
  logic [VW-1:0]                 hx2_q [NH];
  logic [VW-1:0]                 hy1_q [NH];
  logic [VW-1:0]                 hy2_q [NH];

  logic [biq_pkg::OP_W-1:0]      in_op;
  logic [SW-1:0]                 in_si;
  logic [SW-1:0]                 in_sq;
  logic [biq_pkg::IDX_W-1:0]     in_idx;
  logic [COEF_WIDTH-1:0]         in_cv;
  logic                          in_acc;
  logic [ST_W-1:0]               n_stages;
  logic [CI_W-1:0]               ci;
  logic [HI_W-1:0]               hi;
  logic [VW-1:0]                 opnd;
  biq_pkg::mac_ctrl_t            mac_ctrl;
  logic                          mac_busy;
  logic [AW-1:0]                 mac_acc;
  logic [AW-1:0]                 rnd;
  logic [AW-FRAC-1:0]            rsh;
  logic                          y_sat;
  logic [VW-1:0]                 y_val;
  logic [VW:0]                   orn;
  logic [VW-SH:0]                osh;
  logic                          o_sat;
  logic [SW-1:0]                 o_val;
  logic                          out_free;

  assign in_op  = s_axis_tdata[P_S_I-1:0];
  assign in_si  = s_axis_tdata[P_S_Q-1:P_S_I];
  assign in_sq  = s_axis_tdata[P_IDX-1:P_S_Q];
  assign in_idx = s_axis_tdata[P_CV-1:P_IDX];
  assign in_cv  = s_axis_tdata[P_CV+COEF_WIDTH-1:P_CV];

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign n_stages      = (32'(active_q) > MAX_STAGES) ? ST_W'(MAX_STAGES) : ST_W'(active_q);
  assign ci            = CI_W'(32'(stage_q) * biq_pkg::SLOTS + 32'(term_q));
  assign hi            = HI_W'(32'(stage_q) * 2 + 32'(chan_q));
  assign out_free      = !out_valid_q || m_axis_tready;

  always_comb begin
    case (term_q)
      biq_pkg::TERM_B0: opnd = x_q;
      biq_pkg::TERM_B1: opnd = hx1_q[hi];
      biq_pkg::TERM_B2: opnd = hx2_q[hi];
      biq_pkg::TERM_A1: opnd = hy1_q[hi];
      biq_pkg::TERM_A2: opnd = hy2_q[hi];
      default:          opnd = '0;
    endcase
  end

  assign mac_ctrl.start  = (state_q == S_LOAD);
  assign mac_ctrl.clear  = (term_q == biq_pkg::TERM_B0);
  assign mac_ctrl.negate = (term_q == biq_pkg::TERM_A1) || (term_q == biq_pkg::TERM_A2);

  biq_mac #(
    .CW (COEF_WIDTH),
    .AW (AW)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .opnd_i (opnd),
    .coef_i (coef_q[ci]),
    .busy_o (mac_busy),
    .acc_o  (mac_acc)
  );

  // round to nearest, ties up, then clamp to the stage range
  assign rnd   = mac_acc + (AW'(1) << (FRAC - 1));
  assign rsh   = rnd[AW-1:FRAC];
  assign y_sat = !((&rsh[AW-FRAC-1:VW-1]) || !(|rsh[AW-FRAC-1:VW-1]));
  assign y_val = y_sat ? (rsh[AW-FRAC-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}})
                       : rsh[VW-1:0];

  assign orn   = {x_q[VW-1], x_q} + ((VW+1)'(1) << (SH - 1));
  assign osh   = orn[VW:SH];
  assign o_sat = !((&osh[VW-SH:SW-1]) || !(|osh[VW-SH:SW-1]));
  assign o_val = o_sat ? (osh[VW-SH] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}})
                       : osh[SW-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && in_op == biq_pkg::OP_FILTER) begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        state_d = (stage_q < n_stages) ? S_LOAD : S_CHEND;
      end
      S_LOAD: begin
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (!mac_busy) begin
          state_d = (term_q == biq_pkg::TERM_A2) ? S_FIN : S_LOAD;
        end
      end
      S_FIN: begin
        state_d = S_CHK;
      end
      S_CHEND: begin
        if (!chan_q) begin
          state_d = S_CHK;
        end else if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= biq_pkg::STAGES_W'(MAX_STAGES);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
      end
      if (state_q == S_CHEND && chan_q && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NC; k++) begin
        coef_q[k] <= '0;
      end
      for (int k = 0; k < NH; k++) begin
        hx1_q[k] <= '0;
        hx2_q[k] <= '0;
        hy1_q[k] <= '0;
        hy2_q[k] <= '0;
      end
    end else begin
      if (in_acc && in_op == biq_pkg::OP_COEF && 32'(in_idx) < NC) begin
        coef_q[CI_W'(in_idx)] <= in_cv;
      end
      if (in_acc && in_op == biq_pkg::OP_CLEAR) begin
        for (int k = 0; k < NH; k++) begin
          hx1_q[k] <= '0;
          hx2_q[k] <= '0;
          hy1_q[k] <= '0;
          hy2_q[k] <= '0;
        end
      end else if (state_q == S_FIN) begin
        hx2_q[hi] <= hx1_q[hi];
        hx1_q[hi] <= x_q;
        hy2_q[hi] <= hy1_q[hi];
        hy1_q[hi] <= y_val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          x_q      <= VW'($signed(in_si)) << SH;
          samp_q_q <= in_sq;
          stage_q  <= '0;
          chan_q   <= 1'b0;
          clip_q   <= 1'b0;
        end
      end
      S_CHK: begin
        term_q <= biq_pkg::TERM_B0;
      end
      S_WAIT: begin
        if (!mac_busy && term_q != biq_pkg::TERM_A2) begin
          term_q <= term_q + 3'd1;
        end
      end
      S_FIN: begin
        x_q     <= y_val;
        clip_q  <= clip_q | y_sat;
        stage_q <= stage_q + ST_W'(1);
      end
      S_CHEND: begin
        if (!chan_q) begin
          res_i_q <= o_val;
          clip_q  <= clip_q | o_sat;
          chan_q  <= 1'b1;
          stage_q <= '0;
          x_q     <= VW'($signed(samp_q_q)) << SH;
        end else if (out_free) begin
          out_data_q <= {o_val, res_i_q};
          out_clip_q <= clip_q | o_sat;
        end
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_clip_q;

endmodule
`default_nettype wire

// ===== sim/biq_checker.sv =====
`timescale 1ns / 100ps
`default_nettype none
module biq_checker (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire  [2:0]  cfg_wdata_i,
  input  wire         s_axis_tvalid,
  input  wire         s_axis_tready,
  input  wire  [87:0] s_axis_tdata,
  input  wire         m_axis_tvalid,
  input  wire         m_axis_tready,
  input  wire  [47:0] m_axis_tdata,
  input  wire         m_axis_tuser,
  output int          errors_o,
  output int          pending_o
);

  localparam int NCOEF = 30;
  localparam int NHIST = 24;
  localparam int CFRAC = 28;

  typedef struct {
    logic signed [23:0] fi;
    logic signed [23:0] fq;
    logic               clip;
  } pair_t;

  pair_t  expected_pairs[$];
  longint coef_tab[NCOEF];
  longint x_hist[NHIST];
  longint y_hist[NHIST];
  logic [2:0] n_sections;

  function automatic longint clamp(longint v, int w, inout bit c);
    longint hi, lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      c = 1;
      return hi;
    end
    if (v < lo) begin
      c = 1;
      return lo;
    end
    return v;
  endfunction

  function automatic longint run_section(int st, int ch, longint x, inout bit c);
    longint cf[5];
    longint vals[5];
    longint hs, ls, p, y;
    int h;
    h = (st * 2 + ch) * 2;
    cf[0] = coef_tab[st*5 + biq_pkg::TERM_B0];
    cf[1] = coef_tab[st*5 + biq_pkg::TERM_B1];
    cf[2] = coef_tab[st*5 + biq_pkg::TERM_B2];
    cf[3] = -coef_tab[st*5 + biq_pkg::TERM_A1];
    cf[4] = -coef_tab[st*5 + biq_pkg::TERM_A2];
    vals[0] = x;
    vals[1] = x_hist[h];
    vals[2] = x_hist[h+1];
    vals[3] = y_hist[h];
    vals[4] = y_hist[h+1];
    hs = 0;
    ls = 0;
    for (int k = 0; k < 5; k++) begin
      p = cf[k] * vals[k];
      hs += p >>> CFRAC;
      ls += p & ((longint'(1) <<< CFRAC) - 1);
    end
    y = hs + ((ls + (longint'(1) <<< (CFRAC - 1))) >>> CFRAC);
    y = clamp(y, 32, c);
    x_hist[h+1] = x_hist[h];
    x_hist[h] = x;
    y_hist[h+1] = y_hist[h];
    y_hist[h] = y;
    return y;
  endfunction

  function automatic logic [23:0] filter_chan(int ch, logic signed [23:0] s, inout bit c);
    longint v;
    v = longint'(s) * 2;
    for (int st = 0; st < 6; st++)
      if (st < n_sections) v = run_section(st, ch, v, c);
    v = (v + 1) >>> 1;
    v = clamp(v, 24, c);
    return v[23:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pair_t e, got;
    bit    c;
    logic [1:0] op;
    if (!rst_ni) begin
      expected_pairs.delete();
      foreach (coef_tab[k]) coef_tab[k] = 0;
      foreach (x_hist[k]) begin
        x_hist[k] = 0;
        y_hist[k] = 0;
      end
      n_sections = 3'd6;
      errors_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) n_sections = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        op = s_axis_tdata[1:0];
        if (op == biq_pkg::OP_FILTER) begin
          c = 0;
          e.fi = filter_chan(0, s_axis_tdata[25:2], c);
          e.fq = filter_chan(1, s_axis_tdata[49:26], c);
          e.clip = c;
          expected_pairs.push_back(e);
        end else if (op == biq_pkg::OP_COEF) begin
          if (s_axis_tdata[54:50] < NCOEF)
            coef_tab[s_axis_tdata[54:50]] = longint'($signed(s_axis_tdata[86:55]));
        end else if (op == biq_pkg::OP_CLEAR) begin
          foreach (x_hist[k]) begin
            x_hist[k] = 0;
            y_hist[k] = 0;
          end
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.fi = m_axis_tdata[23:0];
        got.fq = m_axis_tdata[47:24];
        got.clip = m_axis_tuser;
        if (expected_pairs.size() == 0) begin
          $error("unexpected result word fi=%0d fq=%0d", got.fi, got.fq);
          errors_o++;
        end else begin
          e = expected_pairs.pop_front();
          if (got.fi !== e.fi) begin
            $error("filtered_i expected %0d got %0d", e.fi, got.fi);
            errors_o++;
          end
          if (got.fq !== e.fq) begin
            $error("filtered_q expected %0d got %0d", e.fq, got.fq);
            errors_o++;
          end
          if (got.clip !== e.clip) begin
            $error("clipped expected %0d got %0d", e.clip, got.clip);
            errors_o++;
          end
        end
      end
      pending_o = expected_pairs.size();
    end
  end
endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int LIMIT = 4000000;
  localparam logic signed [23:0] SMAX = 24'sh7fffff;
  localparam logic signed [23:0] SMIN = 24'sh800000;
  localparam logic signed [31:0] ONE = 32'sh10000000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [2:0]  cfg_wdata_i = 0;
  logic        s_axis_tvalid = 0;
  wire         s_axis_tready;
  logic [87:0] s_axis_tdata = '0;
  wire         m_axis_tvalid;
  logic        m_axis_tready = 0;
  wire  [47:0] m_axis_tdata;
  wire         m_axis_tuser;
  int          errors, pending;
  bit          idle_en = 1;
  bit          hold_req = 0;
  int          cycles = 0;

  iq_biquad_cascade_lowpass dut (.*);

  biq_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 0;
        m_axis_tready <= 0;
        repeat (3000) @(posedge clk_i);
      end else begin
        m_axis_tready <= idle_en ? ($urandom_range(99) >= 11) : 1'b1;
      end
    end
  end

  task automatic send_word(logic [1:0] op, logic [23:0] si, logic [23:0] sq,
                           logic [4:0] idx, logic [31:0] val);
    if (idle_en && $urandom_range(99) < 11) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tdata <= {1'b0, val, idx, sq, si, op};
    s_axis_tvalid <= 1;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
  endtask

  task automatic filter_pair(logic [23:0] si, logic [23:0] sq);
    send_word(biq_pkg::OP_FILTER, si, sq, 5'($urandom), $urandom);
  endtask

  task automatic write_coef(int idx, logic [31:0] val);
    send_word(biq_pkg::OP_COEF, 24'($urandom), 24'($urandom), 5'(idx), val);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    do @(negedge clk_i); while (pending != 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_sections(logic [2:0] n);
    drain();
    cfg_we_i <= 1;
    cfg_wdata_i <= n;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  function automatic logic [31:0] rand_coef();
    if ($urandom_range(1)) return $urandom;
    return $urandom_range(0, 32'h20000000) - 32'h10000000;
  endfunction

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(7))
      0: return SMAX;
      1: return SMIN;
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic random_item();
    int r;
    r = $urandom_range(99);
    if (r < 60) filter_pair(rand_sample(), rand_sample());
    else if (r < 88) write_coef($urandom_range(31), rand_coef());
    else if (r < 94) send_word(biq_pkg::OP_CLEAR, 24'($urandom), 24'($urandom),
                               5'($urandom), $urandom);
    else send_word(OP_NONE, 24'($urandom), 24'($urandom), 5'($urandom), $urandom);
  endtask

  task automatic run_phase(logic [2:0] n, int count, bit pressure);
    set_sections(n);
    for (int k = 0; k < 30; k++) write_coef(k, rand_coef());
    for (int k = 0; k < count; k++) begin
      if (pressure && k == count / 3) hold_req = 1;
      if (k == count / 2) drain();
      if (k == count / 4) idle_en = 0;
      if (k == count / 4 + 40) idle_en = 1;
      random_item();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    filter_pair(SMAX, SMIN);
    write_coef(5*0 + biq_pkg::TERM_B0, ONE);
    filter_pair(SMIN, SMAX);
    set_sections(3'd0);
    filter_pair(SMAX, SMIN);
    filter_pair(SMIN, 24'd1);
    set_sections(3'd1);
    filter_pair(SMAX, SMIN);
    filter_pair(24'd0, 24'hffffff);
    write_coef(5*0 + biq_pkg::TERM_B1, 32'h7fffffff);
    write_coef(5*0 + biq_pkg::TERM_A1, 32'h80000000);
    filter_pair(SMAX, SMAX);
    filter_pair(SMIN, SMIN);
    write_coef(30, ONE);
    write_coef(31, 32'h80000000);
    send_word(biq_pkg::OP_CLEAR, 0, 0, 0, 0);
    filter_pair(SMAX, SMIN);
    send_word(OP_NONE, SMAX, SMAX, 5'd31, 32'hffffffff);
    write_coef(5*0 + biq_pkg::TERM_B2, ONE);
    write_coef(5*0 + biq_pkg::TERM_A2, -ONE);
    filter_pair(24'h400000, 24'hc00000);
    filter_pair(24'h400000, 24'hc00000);

    run_phase(3'd1, 200, 1);
    run_phase(3'd2, 200, 0);
    run_phase(3'd0, 100, 0);
    run_phase(3'd7, 60, 0);
    run_phase(3'd3, 150, 1);
    run_phase(3'd5, 100, 0);
    run_phase(3'd6, 20, 0);

    drain();
    repeat (100) @(posedge clk_i);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
sv/biq_pkg.sv
sv/biq_mac.sv
sv/iq_biquad_cascade_lowpass.sv
sim/biq_checker.sv
sim/tb.sv
